// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the shadow call stack rtl
// expects clk and rst in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ===== hw/rtl/scsu_pkg.sv =====
// shared types and codes for the shadow call stack unwinder
// no dependencies
package scsu_pkg;

  localparam int WORD_W     = 64;
  localparam int ACT_W      = 2;
  localparam int THR_W      = 2;
  localparam int CNT_W      = 7;
  localparam int ST_W       = 2;
  localparam int DUMP_CNT_W = 6;   // counts up to 64 dumped records
  localparam int REC_W      = 3 * WORD_W;

  // action codes
  localparam logic [ACT_W-1:0] ACT_CALL = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RET  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DUMP = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK         = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW   = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDERFLOW  = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY_DUMP = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [THR_W-1:0]  thread;
    logic [WORD_W-1:0] stack_ptr;
    logic [WORD_W-1:0] call_target;
    logic [WORD_W-1:0] call_addr;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [CNT_W-1:0]  discarded;
    logic [CNT_W-1:0]  depth_now;
    logic              rec_valid;
    logic [WORD_W-1:0] rec_target;
    logic [WORD_W-1:0] rec_addr;
    logic              last;
  } rsp_t;

  // record memory read address source
  typedef enum logic [1:0] {
    RD_REQ  = 2'd0,
    RD_POP  = 2'd1,
    RD_DUMP = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    pop;
    logic    dump_emit;
    logic    fin_emit;
  } dp_cmd_t;

  typedef struct packed {
    logic             req_in_range;
    logic [ACT_W-1:0] req_action;
    logic             req_depth_zero;
    logic             sp_ge;
    logic             depth_one;
    logic             dump_last;
    logic             rsp_free;
  } dp_stat_t;

endpackage

// ===== hw/rtl/scsu_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module scsu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/scsu_ctrl.sv =====
// sequencing state machine for the shadow call stack unwinder
// depends on scsu_pkg
module scsu_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  scsu_pkg::dp_stat_t stat,
  output scsu_pkg::dp_cmd_t  cmd
);
  import scsu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_UNWIND = 4'b0010,
    S_DUMP   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   req_uses_stack;

  assign req_uses_stack = stat.req_in_range && !stat.req_depth_zero &&
                          (stat.req_action == ACT_CALL || stat.req_action == ACT_RET ||
                           stat.req_action == ACT_DUMP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_REQ;
    state_next = state;
    req_stall  = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          if (req_uses_stack) begin
            // fetch the top record of the thread
            cmd.rd_en  = 1'b1;
            state_next = (stat.req_action == ACT_DUMP) ? S_DUMP : S_UNWIND;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_UNWIND: begin
        if (stat.sp_ge) begin
          cmd.pop = 1'b1;
          if (!stat.depth_one) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_POP;
          end else begin
            state_next = S_FINISH;
          end
        end else begin
          state_next = S_FINISH;
        end
      end
      S_DUMP: begin
        if (stat.rsp_free) begin
          cmd.dump_emit = 1'b1;
          if (!stat.dump_last) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_DUMP;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_FINISH: begin
        if (stat.rsp_free) begin
          cmd.fin_emit = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/scsu_dp.sv =====
// datapath: depth table, record memory, unwind compare, result register
// depends on scsu_pkg, scsu_ram and assert_macros.svh
`include "assert_macros.svh"
module scsu_dp #(
  parameter int THREADS = 4,
  parameter int DEPTH   = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  scsu_pkg::req_t     req_item,
  input  scsu_pkg::dp_cmd_t  cmd,
  output scsu_pkg::dp_stat_t stat,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output scsu_pkg::rsp_t     rsp_item
);
  import scsu_pkg::*;

  localparam int TH_N      = (THREADS < (1 << THR_W)) ? THREADS : (1 << THR_W);
  localparam int TIW       = (TH_N > 1) ? $clog2(TH_N) : 1;
  localparam int DW        = $clog2(DEPTH + 1);
  localparam int IW        = $clog2(DEPTH);
  localparam int MEM_WORDS = TH_N * DEPTH;
  localparam int AW        = $clog2(MEM_WORDS);

  function automatic logic [AW-1:0] rec_addr_of(input logic [TIW-1:0] tix,
                                                input logic [IW-1:0]  idx);
    rec_addr_of = AW'(int'(tix) * DEPTH + int'(idx));
  endfunction

  logic [DW-1:0] depth_tab [TH_N];

  // incoming item decode
  logic           req_rng;
  logic [TIW-1:0] req_tix;
  logic [DW-1:0]  req_depth;

  // latched item
  logic [ACT_W-1:0]      act;
  logic [TIW-1:0]        tix;
  logic                  rng;
  logic [WORD_W-1:0]     sp;
  logic [WORD_W-1:0]     tgt;
  logic [WORD_W-1:0]     caddr;
  logic [DW-1:0]         d;
  logic [DW-1:0]         disc;
  logic [IW-1:0]         ptr;
  logic [DUMP_CNT_W-1:0] dcnt;

  // record memory
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [REC_W-1:0]  ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [REC_W-1:0]  ram_rdata;
  logic [WORD_W-1:0] rd_sp;
  logic [WORD_W-1:0] rd_tgt;
  logic [WORD_W-1:0] rd_caddr;

  logic          full;
  logic          dzero;
  logic          tab_we;
  logic [DW-1:0] d_after;
  logic          rsp_free;
  logic          dump_last;
  rsp_t          fin_res;
  rsp_t          dump_res;

  assign req_rng   = int'(req_item.thread) < THREADS;
  assign req_tix   = req_item.thread[TIW-1:0];
  assign req_depth = req_rng ? depth_tab[req_tix] : '0;

  assign rd_sp    = ram_rdata[REC_W-1 -: WORD_W];
  assign rd_tgt   = ram_rdata[2*WORD_W-1 -: WORD_W];
  assign rd_caddr = ram_rdata[WORD_W-1:0];

  assign full      = (d == DW'(DEPTH));
  assign dzero     = (d == '0);
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign dump_last = (ptr == '0) || (dcnt == '1);

  assign stat.req_in_range   = req_rng;
  assign stat.req_action     = req_item.action;
  assign stat.req_depth_zero = (req_depth == '0);
  assign stat.sp_ge          = (sp >= rd_sp);
  assign stat.depth_one      = (d == DW'(1));
  assign stat.dump_last      = dump_last;
  assign stat.rsp_free       = rsp_free;

  always_comb begin
    case (cmd.rd_sel)
      RD_REQ:  ram_raddr = rec_addr_of(req_tix, IW'(req_depth - DW'(1)));
      RD_POP:  ram_raddr = rec_addr_of(tix, IW'(d - DW'(2)));
      RD_DUMP: ram_raddr = rec_addr_of(tix, ptr - IW'(1));
      default: ram_raddr = rec_addr_of(tix, ptr);
    endcase
  end

  // push on a call with room left
  assign ram_we    = cmd.fin_emit && rng && (act == ACT_CALL) && !full;
  assign ram_waddr = rec_addr_of(tix, IW'(d));
  assign ram_wdata = {sp, tgt, caddr};

  scsu_ram #(
    .WIDTH (REC_W),
    .DEPTH (MEM_WORDS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign tab_we = cmd.fin_emit && rng && (act == ACT_CALL || act == ACT_RET);

  always_comb begin
    d_after = d;
    if (act == ACT_CALL && !full) begin
      d_after = d + DW'(1);
    end else if (act == ACT_RET && !dzero) begin
      d_after = d - DW'(1);
    end
  end

  always_comb begin
    fin_res      = '0;
    fin_res.last = 1'b1;
    if (rng) begin
      case (act)
        ACT_CALL: begin
          fin_res.status    = full ? ST_OVERFLOW : ST_OK;
          fin_res.discarded = CNT_W'(disc);
          fin_res.depth_now = CNT_W'(d_after);
        end
        ACT_RET: begin
          fin_res.status    = dzero ? ST_UNDERFLOW : ST_OK;
          fin_res.discarded = CNT_W'(disc);
          fin_res.depth_now = CNT_W'(d_after);
        end
        ACT_DUMP: begin
          fin_res.status = ST_EMPTY_DUMP;
        end
        default: begin
          fin_res.depth_now = CNT_W'(d);
        end
      endcase
    end
  end

  always_comb begin
    dump_res            = '0;
    dump_res.status     = ST_OK;
    dump_res.depth_now  = CNT_W'(d);
    dump_res.rec_valid  = 1'b1;
    dump_res.rec_target = rd_tgt;
    dump_res.rec_addr   = rd_caddr;
    dump_res.last       = dump_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TH_N; i++) begin
        depth_tab[i] <= '0;
      end
      rsp_valid <= 1'b0;
    end else begin
      if (tab_we) begin
        depth_tab[tix] <= d_after;
      end
      if (cmd.fin_emit || cmd.dump_emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act   <= req_item.action;
      tix   <= req_tix;
      rng   <= req_rng;
      sp    <= req_item.stack_ptr;
      tgt   <= req_item.call_target;
      caddr <= req_item.call_addr;
      d     <= req_depth;
      disc  <= '0;
      ptr   <= IW'(req_depth - DW'(1));
      dcnt  <= '0;
    end else begin
      if (cmd.pop) begin
        d    <= d - DW'(1);
        disc <= disc + DW'(1);
      end
      if (cmd.dump_emit) begin
        ptr  <= ptr - IW'(1);
        dcnt <= dcnt + DUMP_CNT_W'(1);
      end
    end
    if (cmd.fin_emit) begin
      rsp_item <= fin_res;
    end else if (cmd.dump_emit) begin
      rsp_item <= dump_res;
    end
  end

  `ASSERT_NEVER(a_emit_into_busy, (cmd.fin_emit || cmd.dump_emit) && !rsp_free, "result overwritten while stalled")
  `ASSERT_NEVER(a_pop_empty, cmd.pop && dzero, "unwind pop on an empty stack")
  `ASSERT_NEVER(a_push_full, ram_we && (d >= DW'(DEPTH)), "push beyond stack depth")
  `ASSERT_NEVER(a_dump_ptr, cmd.dump_emit && (DW'(ptr) >= d), "dump pointer outside the stack")

endmodule

// ===== hw/rtl/shadow_call_stack_unwinder_top.sv =====
// Shadow call stack with longjmp unwinding, one stack per thread. A call or
// return first pops every top record whose saved stack pointer is at or below
// the incoming one, then a call pushes {stack_ptr, call_target, call_addr} and
// a return pops one more record; a dump sends the records top first, one
// transfer per record (at most 64). Each request is worked alone: it is taken
// in the idle state, a call or return then compares its stack pointer against
// one record at a time in the unwind state, and the finish state writes back
// the depth and posts its result; a request on an empty stack or for a thread
// out of range goes straight to the finish state. Posting, of a finish result
// or of a dump record, waits while the result register is stalled. The single
// read port of the record memory, whose registered read lets one record be
// examined per cycle (in a dump only while the result register is free), sets
// this pace. Records are held in a memory of min(THREADS, 4) x DEPTH words
// with no clearing pass after reset, only entries below a thread's depth are
// ever read; per-thread depths reset to zero. A thread number at or above
// THREADS is answered with a result that is zero but for last and touches
// nothing.
// depends on scsu_pkg, scsu_ctrl, scsu_dp
module shadow_call_stack_unwinder_top #(
  parameter int THREADS = 4,
  parameter int DEPTH   = 64
) (
  input  logic           clk,
  input  logic           rst,
  // request channel
  input  logic           req_valid,
  output logic           req_stall,
  input  scsu_pkg::req_t req_item,
  // result channel
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output scsu_pkg::rsp_t rsp_item
);
  import scsu_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: accept, unwind compare loop, dump loop, finish
  scsu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // depth table, record memory and result register
  scsu_dp #(
    .THREADS (THREADS),
    .DEPTH   (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_item  (req_item),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
  );

endmodule

// ===== sim/shadow_call_stack_unwinder_checker.sv =====
// transfer monitor and stack predictor for the shadow call stack unwinder
// keeps its own per-thread record stacks and compares every result transfer
// depends on scsu_pkg
`timescale 1ns / 1ps

module scsu_checker #(
  parameter int THREADS = 4,
  parameter int DEPTH   = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  scsu_pkg::req_t req_item,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  scsu_pkg::rsp_t rsp_item,
  output int             bad_reports,
  output int             reports_due
);
  import scsu_pkg::*;

  localparam int DUMP_MAX = 1 << DUMP_CNT_W;

  logic [WORD_W-1:0] frame_sp  [THREADS][DEPTH];
  logic [WORD_W-1:0] frame_tgt [THREADS][DEPTH];
  logic [WORD_W-1:0] frame_site[THREADS][DEPTH];
  int                frame_cnt [THREADS];

  rsp_t stack_reports_due[$];
  rsp_t want;
  int   faults;

  // apply one request to the shadow stacks and queue the reports it causes
  task automatic track_stack_event(input req_t ev);
    rsp_t rep;
    int   t;
    int   dropped;
    int   shown;
    int   i;
    rep = '0;
    rep.last = 1'b1;
    if (ev.thread >= THREADS) begin
      stack_reports_due = {stack_reports_due, rep};
      return;
    end
    t = int'(ev.thread);
    case (ev.action)
      ACT_CALL, ACT_RET: begin
        // longjmp recovery: drop stale frames at or below the new sp
        dropped = 0;
        while (frame_cnt[t] > 0 && ev.stack_ptr >= frame_sp[t][frame_cnt[t]-1]) begin
          frame_cnt[t]--;
          dropped++;
        end
        if (ev.action == ACT_CALL) begin
          if (frame_cnt[t] >= DEPTH) begin
            rep.status = ST_OVERFLOW;
          end else begin
            frame_sp[t][frame_cnt[t]]   = ev.stack_ptr;
            frame_tgt[t][frame_cnt[t]]  = ev.call_target;
            frame_site[t][frame_cnt[t]] = ev.call_addr;
            frame_cnt[t]++;
          end
        end else if (frame_cnt[t] == 0) begin
          rep.status = ST_UNDERFLOW;
        end else begin
          frame_cnt[t]--;
        end
        rep.discarded = CNT_W'(dropped);
        rep.depth_now = CNT_W'(frame_cnt[t]);
        stack_reports_due = {stack_reports_due, rep};
      end
      ACT_DUMP: begin
        if (frame_cnt[t] == 0) begin
          rep.status = ST_EMPTY_DUMP;
          stack_reports_due = {stack_reports_due, rep};
        end else begin
          shown = (frame_cnt[t] < DUMP_MAX) ? frame_cnt[t] : DUMP_MAX;
          for (i = 0; i < shown; i++) begin
            rep.depth_now  = CNT_W'(frame_cnt[t]);
            rep.rec_valid  = 1'b1;
            rep.rec_target = frame_tgt[t][frame_cnt[t]-1-i];
            rep.rec_addr   = frame_site[t][frame_cnt[t]-1-i];
            rep.last       = (i == shown - 1);
            stack_reports_due = {stack_reports_due, rep};
          end
        end
      end
      default: begin
        rep.depth_now = CNT_W'(frame_cnt[t]);
        stack_reports_due = {stack_reports_due, rep};
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < THREADS; t++) frame_cnt[t] = 0;
      stack_reports_due.delete();
      faults = 0;
    end else begin
      if (req_valid && !req_stall) track_stack_event(req_item);
      if (rsp_valid && !rsp_stall) begin
        if (stack_reports_due.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("unexpected report: st=%0d disc=%0d depth=%0d v=%0b tgt=%h addr=%h last=%0b",
                     rsp_item.status, rsp_item.discarded, rsp_item.depth_now,
                     rsp_item.rec_valid, rsp_item.rec_target, rsp_item.rec_addr,
                     rsp_item.last);
        end else begin
          want = stack_reports_due.pop_front();
          if (want.status !== rsp_item.status || want.discarded !== rsp_item.discarded ||
              want.depth_now !== rsp_item.depth_now || want.rec_valid !== rsp_item.rec_valid ||
              want.rec_target !== rsp_item.rec_target ||
              want.rec_addr !== rsp_item.rec_addr || want.last !== rsp_item.last) begin
            faults++;
            if (faults <= 10) begin
              $display("report mismatch at %0t", $realtime);
              $display("  want st=%0d disc=%0d depth=%0d v=%0b tgt=%h addr=%h last=%0b",
                       want.status, want.discarded, want.depth_now, want.rec_valid,
                       want.rec_target, want.rec_addr, want.last);
              $display("  got  st=%0d disc=%0d depth=%0d v=%0b tgt=%h addr=%h last=%0b",
                       rsp_item.status, rsp_item.discarded, rsp_item.depth_now,
                       rsp_item.rec_valid, rsp_item.rec_target, rsp_item.rec_addr,
                       rsp_item.last);
            end
          end
        end
      end
    end
    bad_reports <= faults;
    reports_due <= stack_reports_due.size();
  end

endmodule

// ===== sim/tb_shadow_call_stack_unwinder_top.sv =====
// testbench top for the shadow call stack unwinder: clock, reset, request
// stimulus, result-side stalls and the verdict; checking lives in scsu_checker
// depends on scsu_pkg, scsu_checker and shadow_call_stack_unwinder_top
`timescale 1ns / 1ps

module tb_shadow_call_stack_unwinder_top;
  import scsu_pkg::*;

  localparam int THREADS      = 4;
  localparam int DEPTH        = 64;
  localparam int TOTAL_ITEMS  = 460;
  localparam int CALM_TAIL    = 50;     // final items run with no idling at all
  localparam int HOLD_AT      = 150;    // long receiver hold-off starts here
  localparam int PAUSE_AT     = 290;    // sender waits for a full drain here
  localparam int HOLD_CYCLES  = 400;
  localparam int FRAME_STEP   = 4096;   // sp distance between call levels
  localparam int FRAME_JITTER = 2047;   // random sp spread inside one level
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 3_000_000;

  // action code the block treats as a no-op
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_item = '0;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp_item;

  int bad_reports;
  int reports_due;
  int cycle_count = 0;
  int sent = 0;
  bit quiet = 1'b0;         // set for the calm tail of the run
  bit hold_off_req = 1'b0;  // main flow asks the receiver for a long hold-off

  // per-thread call level as the stimulus sees it, and the sp origin of each stack
  int                level  [THREADS];
  logic [WORD_W-1:0] sp_base[THREADS];

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  shadow_call_stack_unwinder_top #(
    .THREADS(THREADS),
    .DEPTH  (DEPTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_item (req_item),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_item (rsp_item)
  );

  scsu_checker #(
    .THREADS(THREADS),
    .DEPTH  (DEPTH)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_item   (req_item),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp_item   (rsp_item),
    .bad_reports(bad_reports),
    .reports_due(reports_due)
  );

  // run limit, far above the slowest legal run
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    rsp_stall = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        rsp_stall <= 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
        rsp_stall <= 1'b0;
        hold_off_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 7) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  function automatic req_t mk_req(input logic [ACT_W-1:0] act, input logic [THR_W-1:0] thr,
                                  input logic [WORD_W-1:0] sp, input logic [WORD_W-1:0] tgt,
                                  input logic [WORD_W-1:0] site);
    req_t r;
    r.action      = act;
    r.thread      = thr;
    r.stack_ptr   = sp;
    r.call_target = tgt;
    r.call_addr   = site;
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // sp inside the band of call level lvl; deeper levels sit lower
  function automatic logic [WORD_W-1:0] level_sp(input int t, input int lvl);
    return sp_base[t] - WORD_W'(lvl * FRAME_STEP) - WORD_W'($urandom_range(0, FRAME_JITTER));
  endfunction

  // sp between the bands of levels lvl-1 and lvl: unwinds exactly down to lvl
  function automatic logic [WORD_W-1:0] unwind_sp(input int t, input int lvl);
    return sp_base[t] - WORD_W'(lvl * FRAME_STEP) + WORD_W'(FRAME_JITTER + 1);
  endfunction

  // present one request and hold it until the transfer happens
  task automatic offer(input req_t r);
    @(negedge clk);
    req_valid <= 1'b1;
    req_item  <= r;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic idle_sender(input int n);
    @(negedge clk);
    req_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // one request, then now and then an idle burst
  task automatic send(input req_t r);
    offer(r);
    sent++;
    if (!quiet && $urandom_range(0, 99) < 12) idle_sender($urandom_range(1, 18));
    if (sent >= TOTAL_ITEMS - CALM_TAIL) quiet = 1'b1;
  endtask

  // stop offering and wait until every queued report has come back
  task automatic wait_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (reports_due != 0) @(negedge clk);
  endtask

  // well-formed call: sp below the caller's frame; refused once the stack is full
  task automatic call_in(input int t);
    send(mk_req(ACT_CALL, THR_W'(t), level_sp(t, level[t]), rand_word(), rand_word()));
    if (level[t] < DEPTH) level[t]++;
  endtask

  // well-formed return pops the top frame; underflows on an empty stack
  task automatic ret_in(input int t);
    send(mk_req(ACT_RET, THR_W'(t), level_sp(t, level[t]), rand_word(), rand_word()));
    if (level[t] > 0) level[t]--;
  endtask

  // longjmp to a random level no deeper than the current one, entered by a call or a return
  task automatic jump_in(input int t, input bit by_call);
    int lvl;
    lvl = $urandom_range(0, level[t]);
    send(mk_req(by_call ? ACT_CALL : ACT_RET, THR_W'(t), unwind_sp(t, lvl),
                rand_word(), rand_word()));
    if (by_call) level[t] = (lvl < DEPTH) ? lvl + 1 : lvl;
    else level[t] = (lvl > 0) ? lvl - 1 : 0;
  endtask

  task automatic dump_in(input int t);
    send(mk_req(ACT_DUMP, THR_W'(t), rand_word(), rand_word(), rand_word()));
  endtask

  // fully random request; a call or return leaves the stack unknown, so the
  // thread is flushed with an all-ones return afterwards
  task automatic noise_in();
    req_t r;
    r = mk_req(ACT_W'($urandom_range(0, 3)), THR_W'($urandom_range(0, THREADS - 1)),
               rand_word(), rand_word(), rand_word());
    send(r);
    if (r.action == ACT_CALL || r.action == ACT_RET) begin
      send(mk_req(ACT_RET, r.thread, ALL_ONES, rand_word(), rand_word()));
      level[r.thread] = 0;
    end
  endtask

  // one random-content step, weighted by the episode's call and return shares
  task automatic mixed_step(input int t, input int call_pct, input int ret_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < call_pct) call_in(t);
    else if (roll < call_pct + ret_pct) ret_in(t);
    else if (roll < 93) dump_in(t);
    else jump_in(t, roll[0]);
  endtask

  // push one stack to the limit, overflow it, dump all 64 frames, unwind
  task automatic fill_stack(input int t);
    while (level[t] < DEPTH) call_in(t);
    repeat ($urandom_range(1, 3)) call_in(t);
    dump_in(t);
    jump_in(t, 1'b0);
  endtask

  initial begin
    int t;
    int pick;
    int fills;
    bit held;
    bit paused;

    fills  = 0;
    held   = 1'b0;
    paused = 1'b0;
    for (int i = 0; i < THREADS; i++) begin
      level[i]   = 0;
      sp_base[i] = {2'b10, 30'($urandom), 32'($urandom)};
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty-stack cases and the no-op code first
    send(mk_req(ACT_DUMP, 2'd0, '0, '0, '0));
    send(mk_req(ACT_RET, 2'd1, '0, '0, '0));
    send(mk_req(ACT_SPARE, 2'd2, ALL_ONES, ALL_ONES, ALL_ONES));
    // extreme sp values, equal sp counts as stale
    send(mk_req(ACT_CALL, 2'd0, ALL_ONES, ALL_ONES, '0));
    send(mk_req(ACT_CALL, 2'd0, ALL_ONES, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210));
    send(mk_req(ACT_CALL, 2'd0, 64'h8000_0000_0000_0000, '0, ALL_ONES));
    send(mk_req(ACT_CALL, 2'd0, '0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
    send(mk_req(ACT_CALL, 2'd0, '0, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555));
    send(mk_req(ACT_DUMP, 2'd0, '0, '0, '0));
    send(mk_req(ACT_RET, 2'd0, '0, '0, '0));
    send(mk_req(ACT_SPARE, 2'd0, '0, '0, '0));
    // longjmp return across two frames, then underflow
    send(mk_req(ACT_CALL, 2'd3, 64'd1000, 64'h1000, 64'h2000));
    send(mk_req(ACT_CALL, 2'd3, 64'd900, 64'h1100, 64'h2100));
    send(mk_req(ACT_CALL, 2'd3, 64'd800, 64'h1200, 64'h2200));
    send(mk_req(ACT_DUMP, 2'd3, '0, '0, '0));
    send(mk_req(ACT_RET, 2'd3, 64'd950, '0, '0));
    send(mk_req(ACT_RET, 2'd3, 64'd5, '0, '0));
    // unwinding empties the stack before the pop: underflow with a discard
    send(mk_req(ACT_CALL, 2'd1, 64'd100, ALL_ONES, ALL_ONES));
    send(mk_req(ACT_RET, 2'd1, 64'd200, '0, '0));
    send(mk_req(ACT_DUMP, 2'd1, '0, '0, '0));
    send(mk_req(ACT_CALL, 2'd2, 64'd500, 64'hDEAD_BEEF_0000_0001, 64'h0000_0001_DEAD_BEEF));
    send(mk_req(ACT_CALL, 2'd2, 64'd400, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001));
    send(mk_req(ACT_CALL, 2'd2, ALL_ONES, '0, '0));

    // flush every thread so the random part starts from known levels
    for (int i = 0; i < THREADS; i++) send(mk_req(ACT_RET, THR_W'(i), ALL_ONES, '0, '0));

    // first random episode always fills a stack to overflow
    fill_stack($urandom_range(0, THREADS - 1));
    fills++;

    while (sent < TOTAL_ITEMS) begin
      if (!held && sent >= HOLD_AT) begin
        // receiver holds off while the sender keeps offering dumps
        held = 1'b1;
        hold_off_req = 1'b1;
        for (int i = 0; i < THREADS; i++) dump_in(i);
      end
      if (!paused && sent >= PAUSE_AT) begin
        paused = 1'b1;
        wait_drained();
      end
      t    = $urandom_range(0, THREADS - 1);
      pick = $urandom_range(0, 99);
      if (pick < 10 && fills < 3) begin
        fill_stack(t);
        fills++;
      end else if (pick < 45) begin
        repeat ($urandom_range(8, 30)) mixed_step(t, 75, 10);
      end else if (pick < 90) begin
        repeat ($urandom_range(8, 30)) mixed_step(t, 45, 40);
      end else begin
        repeat ($urandom_range(1, 4)) noise_in();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_reports == 0 && reports_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
